FILE: hdl/aabb_collision_test_defines.svh
// Shared assertion macros for the box collision tester.
`ifndef AABB_COLLISION_TEST_DEFINES_SVH
`define AABB_COLLISION_TEST_DEFINES_SVH

// Check cons in the same cycle as ante.
`define AABB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("aabb assertion failed");

// Check cons in the cycle after ante.
`define AABB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("aabb assertion failed");

`endif

FILE: hdl/aabb_pkg.sv
package aabb_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int DSUM_W     = COORD_W + 2;
    localparam int MAN_W      = COORD_W + 3;
    localparam int CULL_W     = COORD_W + 1;
    localparam int CFG_DATA_W = CULL_W;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic signed [DSUM_W-1:0]  dsum_t;
    typedef logic [DSUM_W-1:0]         dabs_t;
    typedef logic [MAN_W-1:0]          man_t;
    typedef logic [CULL_W-1:0]         cull_t;
    typedef logic [1:0]                op_t;

    localparam op_t OP_POINT   = 2'd0;
    localparam op_t OP_SEGMENT = 2'd1;
    localparam op_t OP_BOX     = 2'd2;
    localparam op_t OP_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CULL    = 3'd5;

    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } pipe_ctl_t;

    function automatic logic in_unit(num_t n, num_t d);
        logic r;
        if (d < 0) begin
            r = (d <= n) && (n <= 0);
        end else begin
            r = (n >= 0) && (n <= d);
        end
        return r;
    endfunction

    function automatic logic edge_hit(num_t den, num_t na, num_t nb);
        return (den != 0) && in_unit(na, den) && in_unit(nb, den);
    endfunction

endpackage

FILE: hdl/aabb_datapath.sv
module aabb_datapath import aabb_pkg::*; (
    input  logic      aclk,
    input  pipe_ctl_t ctl,
    input  op_t       s_opcode,
    input  coord_t    s_first_x,
    input  coord_t    s_first_y,
    input  coord_t    s_second_x,
    input  coord_t    s_second_y,
    input  logic      s_other_enabled,
    input  logic      s_ignore_disabled,
    input  coord_t    box_min_x,
    input  coord_t    box_min_y,
    input  coord_t    box_max_x,
    input  coord_t    box_max_y,
    input  logic      box_enabled,
    input  cull_t     cull_distance,
    output logic      hit
);

    typedef struct packed {
        op_t   op;
        logic  kill;
        logic  other_kill;
        logic  point_hit;
        logic  overlap;
        diff_t ax;
        diff_t ay;
        diff_t cx;
        diff_t cy;
        diff_t cxp;
        diff_t cyp;
        diff_t h;
        diff_t w;
        dabs_t adx;
        dabs_t ady;
    } s1_t;

    typedef struct packed {
        logic  kill;
        logic  is_seg;
        logic  simple_hit;
        prod_t hax;
        prod_t hcx;
        prod_t way;
        prod_t wcy;
        prod_t wcyp;
        prod_t hcxp;
        prod_t axcy;
        prod_t aycx;
        prod_t axcyp;
        prod_t aycxp;
    } s2_t;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic hit_reg, hit_next;

    dsum_t dx, dy;
    man_t  man;
    logic  culled;
    num_t  nb_low, nb_high;
    logic  seg_hit;

    always_comb begin
        s1_next.op         = s_opcode;
        s1_next.kill       = (!box_enabled && s_ignore_disabled) || (s_opcode == OP_NONE);
        s1_next.other_kill = !s_other_enabled && s_ignore_disabled;
        s1_next.point_hit  = (s_first_x > box_min_x) && (s_first_x < box_max_x) &&
                             (s_first_y > box_min_y) && (s_first_y < box_max_y);
        s1_next.overlap    = (s_first_x < box_max_x) && (s_second_x > box_min_x) &&
                             (s_first_y < box_max_y) && (s_second_y > box_min_y);
        s1_next.ax  = diff_t'(s_second_x) - diff_t'(s_first_x);
        s1_next.ay  = diff_t'(s_second_y) - diff_t'(s_first_y);
        s1_next.cx  = diff_t'(s_first_x) - diff_t'(box_min_x);
        s1_next.cy  = diff_t'(s_first_y) - diff_t'(box_min_y);
        s1_next.cxp = diff_t'(s_first_x) - diff_t'(box_max_x);
        s1_next.cyp = diff_t'(s_first_y) - diff_t'(box_max_y);
        s1_next.h   = diff_t'(box_max_y) - diff_t'(box_min_y);
        s1_next.w   = diff_t'(box_max_x) - diff_t'(box_min_x);
        dx = dsum_t'(diff_t'(box_min_x) + diff_t'(box_max_x)) -
             dsum_t'(diff_t'(s_first_x) + diff_t'(s_second_x));
        dy = dsum_t'(diff_t'(box_min_y) + diff_t'(box_max_y)) -
             dsum_t'(diff_t'(s_first_y) + diff_t'(s_second_y));
        s1_next.adx = (dx < 0) ? dabs_t'(-dx) : dabs_t'(dx);
        s1_next.ady = (dy < 0) ? dabs_t'(-dy) : dabs_t'(dy);
    end

    always_comb begin
        man    = man_t'(s1_reg.adx) + man_t'(s1_reg.ady);
        culled = man > man_t'({cull_distance, 1'b0});
        s2_next.kill   = s1_reg.kill;
        s2_next.is_seg = (s1_reg.op == OP_SEGMENT);
        case (s1_reg.op)
            OP_POINT: s2_next.simple_hit = s1_reg.point_hit;
            OP_BOX:   s2_next.simple_hit = !s1_reg.other_kill && !culled && s1_reg.overlap;
            default:  s2_next.simple_hit = 1'b0;
        endcase
        s2_next.hax   = prod_t'(s1_reg.h) * prod_t'(s1_reg.ax);
        s2_next.hcx   = prod_t'(s1_reg.h) * prod_t'(s1_reg.cx);
        s2_next.hcxp  = prod_t'(s1_reg.h) * prod_t'(s1_reg.cxp);
        s2_next.way   = prod_t'(s1_reg.w) * prod_t'(s1_reg.ay);
        s2_next.wcy   = prod_t'(s1_reg.w) * prod_t'(s1_reg.cy);
        s2_next.wcyp  = prod_t'(s1_reg.w) * prod_t'(s1_reg.cyp);
        s2_next.axcy  = prod_t'(s1_reg.ax) * prod_t'(s1_reg.cy);
        s2_next.aycx  = prod_t'(s1_reg.ay) * prod_t'(s1_reg.cx);
        s2_next.axcyp = prod_t'(s1_reg.ax) * prod_t'(s1_reg.cyp);
        s2_next.aycxp = prod_t'(s1_reg.ay) * prod_t'(s1_reg.cxp);
    end

    always_comb begin
        nb_low  = num_t'(s2_reg.axcy) - num_t'(s2_reg.aycx);
        nb_high = num_t'(s2_reg.axcyp) - num_t'(s2_reg.aycxp);
        seg_hit = edge_hit(num_t'(s2_reg.hax), -num_t'(s2_reg.hcx), nb_low) ||
                  edge_hit(-num_t'(s2_reg.way), num_t'(s2_reg.wcy), nb_low) ||
                  edge_hit(num_t'(s2_reg.way), -num_t'(s2_reg.wcyp), nb_high) ||
                  edge_hit(-num_t'(s2_reg.hax), num_t'(s2_reg.hcxp), nb_high);
        hit_next = !s2_reg.kill && (s2_reg.is_seg ? seg_hit : s2_reg.simple_hit);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load1) begin
            s1_reg <= s1_next;
        end
        if (ctl.load2) begin
            s2_reg <= s2_next;
        end
        if (ctl.load3) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

FILE: hdl/aabb_collision_test.sv
// Three-stage pipeline: setup and compares, products, edge tests.
// An accepted request passes the s1, s2 and hit registers on its way to m_valid.
// Throughput: one request per cycle; a stall holds each full stage in place, while empty stages still fill.
// Reset (aresetn low, synchronous) empties the pipeline and loads the box
// registers with zero corners, box_enabled 1 and cull_distance all ones.
module aabb_collision_test import aabb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  op_t                   s_opcode,
    input  coord_t                s_first_x,
    input  coord_t                s_first_y,
    input  coord_t                s_second_x,
    input  coord_t                s_second_y,
    input  logic                  s_other_enabled,
    input  logic                  s_ignore_disabled,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit
);

    coord_t    min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic      enabled_reg;
    cull_t     cull_reg;
    logic      v1_reg, v2_reg, v3_reg;
    logic      v1_next, v2_next, v3_next;
    pipe_ctl_t ctl;

    always_comb begin
        ctl.load3 = !v3_reg || m_ready;
        ctl.load2 = !v2_reg || ctl.load3;
        ctl.load1 = !v1_reg || ctl.load2;
        v3_next = ctl.load3 ? v2_reg : v3_reg;
        v2_next = ctl.load2 ? v1_reg : v2_reg;
        v1_next = ctl.load1 ? s_valid : v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg   <= '0;
            min_y_reg   <= '0;
            max_x_reg   <= '0;
            max_y_reg   <= '0;
            enabled_reg <= 1'b1;
            cull_reg    <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_X:   min_x_reg   <= cfg_data[COORD_W-1:0];
                REG_MIN_Y:   min_y_reg   <= cfg_data[COORD_W-1:0];
                REG_MAX_X:   max_x_reg   <= cfg_data[COORD_W-1:0];
                REG_MAX_Y:   max_y_reg   <= cfg_data[COORD_W-1:0];
                REG_ENABLED: enabled_reg <= cfg_data[0];
                REG_CULL:    cull_reg    <= cfg_data[CULL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    aabb_datapath u_datapath (
        .aclk              (aclk),
        .ctl               (ctl),
        .s_opcode          (s_opcode),
        .s_first_x         (s_first_x),
        .s_first_y         (s_first_y),
        .s_second_x        (s_second_x),
        .s_second_y        (s_second_y),
        .s_other_enabled   (s_other_enabled),
        .s_ignore_disabled (s_ignore_disabled),
        .box_min_x         (min_x_reg),
        .box_min_y         (min_y_reg),
        .box_max_x         (max_x_reg),
        .box_max_y         (max_y_reg),
        .box_enabled       (enabled_reg),
        .cull_distance     (cull_reg),
        .hit               (m_hit)
    );

    assign s_ready = ctl.load1;
    assign m_valid = v3_reg;

endmodule

FILE: hdl/aabb_checker.sv
`include "aabb_collision_test_defines.svh"

module aabb_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit
);

    `AABB_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_hit))
    `AABB_ASSERT_SAME(a_empty_output_ready, !m_valid, s_ready)
    `AABB_ASSERT_NEXT(a_latency, (s_valid && s_ready ##1 m_ready ##1 m_ready), m_valid)

endmodule

bind aabb_collision_test aabb_checker u_checker (.*);
